/* rtl/core/tbhrc_pkg.sv */
// shared types, codes and reset values for the two-button hold/repeat/combo detector
package tbhrc_pkg;

  // widths of timestamps and configuration registers
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_REPEAT   = 2'd2,
    CFG_COMBO    = 2'd3
  } cfg_idx_e;

  // configuration reset values
  localparam logic [CfgW-1:0] DebounceRst = 16'd150;
  localparam logic [CfgW-1:0] HoldRst     = 16'd600;
  localparam logic [CfgW-1:0] RepeatRst   = 16'd500;
  localparam logic [CfgW-1:0] ComboRst    = 16'd400;

  // per-button action codes
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHORT = 2'd1,
    ACT_STEP  = 2'd2
  } action_e;

  // input request
  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             up_pressed;
    logic             down_pressed;
  } in_t;

  // result request
  typedef struct packed {
    logic [1:0] up_action;
    logic [1:0] down_action;
    logic       toggle_display;
  } out_t;

  // timing thresholds handed to the button units
  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] hold_ms;
    logic [CfgW-1:0] repeat_ms;
  } btn_cfg_t;

  // control from the combo unit to the button units
  typedef struct packed {
    logic en;    // an item is committed this cycle
    logic poll;  // run normal button handling
  } btn_ctl_t;

endpackage

/* rtl/core/two_button_hold_repeat_combo_top.sv */
// top level of the two-button hold/repeat/combo detector
// Takes one sample request per clock and returns exactly one result request per sample, in
// order. A sample is captured in an input register; from there the button and combo logic
// evaluates it against the stored button state and, once the result register is free or
// draining, updates that state and loads the result register. Throughput is one sample per
// cycle, limited only by the result register draining; a stalled output holds the result,
// the input register still takes one more request and then holds it, so the input side
// stalls only while both registers are full. Configuration writes take effect on the next
// cycle and should be made while no sample is in flight.
module two_button_hold_repeat_combo_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tbhrc_pkg::in_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tbhrc_pkg::out_t               out_data_o,
  input  logic                          cfg_we_i,
  input  logic [tbhrc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tbhrc_pkg::CfgW-1:0]    cfg_wdata_i
);

  logic                     s1_valid_q;
  tbhrc_pkg::in_t           s1_data_q;
  logic                     out_valid_q;
  tbhrc_pkg::out_t          out_data_q, out_data_d;
  logic                     advance;
  tbhrc_pkg::btn_cfg_t      btn_cfg_q;
  logic [tbhrc_pkg::CfgW-1:0] combo_ms_q;
  tbhrc_pkg::btn_ctl_t      btn_ctl;
  tbhrc_pkg::action_e       up_act, down_act;
  logic                     toggle;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_cfg_q.debounce_ms <= tbhrc_pkg::DebounceRst;
      btn_cfg_q.hold_ms     <= tbhrc_pkg::HoldRst;
      btn_cfg_q.repeat_ms   <= tbhrc_pkg::RepeatRst;
      combo_ms_q            <= tbhrc_pkg::ComboRst;
    end else if (cfg_we_i) begin
      case (tbhrc_pkg::cfg_idx_e'(cfg_index_i))
        tbhrc_pkg::CFG_DEBOUNCE: btn_cfg_q.debounce_ms <= cfg_wdata_i;
        tbhrc_pkg::CFG_HOLD:     btn_cfg_q.hold_ms     <= cfg_wdata_i;
        tbhrc_pkg::CFG_REPEAT:   btn_cfg_q.repeat_ms   <= cfg_wdata_i;
        tbhrc_pkg::CFG_COMBO:    combo_ms_q            <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake: the sample moves on when the result register is free or draining
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // combo timer and lockout
  tbhrc_combo u_combo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .up_i       (s1_data_q.up_pressed),
    .down_i     (s1_data_q.down_pressed),
    .now_i      (s1_data_q.now_ms),
    .combo_ms_i (combo_ms_q),
    .ctl_o      (btn_ctl),
    .toggle_o   (toggle)
  );

  // per-button handling
  tbhrc_button u_up (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (btn_ctl),
    .cfg_i     (btn_cfg_q),
    .pressed_i (s1_data_q.up_pressed),
    .now_i     (s1_data_q.now_ms),
    .act_o     (up_act)
  );

  tbhrc_button u_down (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (btn_ctl),
    .cfg_i     (btn_cfg_q),
    .pressed_i (s1_data_q.down_pressed),
    .now_i     (s1_data_q.now_ms),
    .act_o     (down_act)
  );

  // result assembly
  always_comb begin
    out_data_d.up_action      = up_act;
    out_data_d.down_action    = down_act;
    out_data_d.toggle_display = toggle;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/core/tbhrc_button.sv */
// one button: hold timer, auto-repeat and short-press detection
module tbhrc_button (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tbhrc_pkg::btn_ctl_t          ctl_i,
  input  tbhrc_pkg::btn_cfg_t          cfg_i,
  input  logic                         pressed_i,
  input  logic [tbhrc_pkg::TimeW-1:0]  now_i,
  output tbhrc_pkg::action_e           act_o
);

  logic                        prev_q, prev_d;
  logic                        hold_done_q, hold_done_d;
  logic [tbhrc_pkg::TimeW-1:0] event_time_q, event_time_d;
  logic [tbhrc_pkg::TimeW-1:0] hold_start_q, hold_start_d;
  logic [tbhrc_pkg::TimeW-1:0] el_hold, el_event;
  tbhrc_pkg::action_e          act;

  // wrapping elapsed times
  assign el_hold  = now_i - hold_start_q;
  assign el_event = now_i - event_time_q;

  // press, hold, repeat and release handling
  always_comb begin
    prev_d       = prev_q;
    hold_done_d  = hold_done_q;
    event_time_d = event_time_q;
    hold_start_d = hold_start_q;
    act          = tbhrc_pkg::ACT_NONE;
    if (ctl_i.poll) begin
      if (pressed_i) begin
        if (!prev_q) begin
          hold_start_d = now_i;
          hold_done_d  = 1'b0;
        end else if (!hold_done_q &&
                     el_hold >= {{(tbhrc_pkg::TimeW-tbhrc_pkg::CfgW){1'b0}}, cfg_i.hold_ms}) begin
          hold_done_d  = 1'b1;
          event_time_d = now_i;
          act          = tbhrc_pkg::ACT_STEP;
        end else if (hold_done_q &&
                     el_event >= {{(tbhrc_pkg::TimeW-tbhrc_pkg::CfgW){1'b0}}, cfg_i.repeat_ms}) begin
          event_time_d = now_i;
          act          = tbhrc_pkg::ACT_STEP;
        end
      end else if (prev_q) begin
        if (!hold_done_q &&
            el_event >= {{(tbhrc_pkg::TimeW-tbhrc_pkg::CfgW){1'b0}}, cfg_i.debounce_ms}) begin
          event_time_d = now_i;
          act          = tbhrc_pkg::ACT_SHORT;
        end
        hold_done_d = 1'b0;
      end
    end
    prev_d = pressed_i;
  end

  assign act_o = act;

  // state registers, updated when an item commits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= 1'b0;
      hold_done_q  <= 1'b0;
      event_time_q <= '0;
      hold_start_q <= '0;
    end else if (ctl_i.en) begin
      prev_q       <= prev_d;
      hold_done_q  <= hold_done_d;
      event_time_q <= event_time_d;
      hold_start_q <= hold_start_d;
    end
  end

endmodule

/* rtl/core/tbhrc_combo.sv */
// two-button combo timer and the lockout that follows a toggle
module tbhrc_combo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         up_i,
  input  logic                         down_i,
  input  logic [tbhrc_pkg::TimeW-1:0]  now_i,
  input  logic [tbhrc_pkg::CfgW-1:0]   combo_ms_i,
  output tbhrc_pkg::btn_ctl_t          ctl_o,
  output logic                         toggle_o
);

  logic                        armed_q, armed_d;
  logic                        done_q, done_d;
  logic [tbhrc_pkg::TimeW-1:0] start_q, start_d;
  logic [tbhrc_pkg::TimeW-1:0] el_combo;
  logic                        both;

  assign both     = up_i & down_i;
  assign el_combo = now_i - start_q;

  // arm, fire once, release lockout when both buttons are up
  always_comb begin
    armed_d  = armed_q;
    done_d   = done_q;
    start_d  = start_q;
    toggle_o = 1'b0;
    if (both) begin
      if (!armed_q) begin
        armed_d = 1'b1;
        start_d = now_i;
      end else if (!done_q &&
                   el_combo >= {{(tbhrc_pkg::TimeW-tbhrc_pkg::CfgW){1'b0}}, combo_ms_i}) begin
        done_d   = 1'b1;
        toggle_o = 1'b1;
      end
    end else begin
      armed_d = 1'b0;
      if (done_q && !up_i && !down_i) begin
        done_d = 1'b0;
      end
    end
  end

  // buttons run normally only outside the combo and its lockout
  assign ctl_o.en   = en_i;
  assign ctl_o.poll = !both && !done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      done_q  <= 1'b0;
      start_q <= '0;
    end else if (en_i) begin
      armed_q <= armed_d;
      done_q  <= done_d;
      start_q <= start_d;
    end
  end

endmodule

/* rtl/core/tbhrc_checker.sv */
// port-level checks for the two-button hold/repeat/combo detector, bound to the top level
module tbhrc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input tbhrc_pkg::out_t               out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input side only stalls behind a full, stalled result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // action codes stay in range
  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.up_action <= tbhrc_pkg::ACT_STEP &&
                    out_data_o.down_action <= tbhrc_pkg::ACT_STEP)
    else $error("undefined action code");

  // a toggle never comes with a button action
  a_toggle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.toggle_display |->
      out_data_o.up_action == tbhrc_pkg::ACT_NONE &&
      out_data_o.down_action == tbhrc_pkg::ACT_NONE)
    else $error("toggle reported together with a button action");

endmodule

bind two_button_hold_repeat_combo_top tbhrc_checker u_tbhrc_checker (.*);
